/* hw/rtl/matmul_pkg.sv */
package matmul_pkg;

  localparam int unsigned REQ_W       = 2;
  localparam int unsigned POS_W       = 3;
  localparam int unsigned ELEM_IN_W   = 16;
  localparam int unsigned OUT_VALUE_W = 35;
  localparam int unsigned DIM_REG_W   = 4;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned WIDE_W      = 64;

  localparam logic [REQ_W-1:0] REQ_WR_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WR_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MUL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

  localparam logic [DIM_REG_W-1:0] DIM_RESET = 4'd8;

  typedef enum logic [1:0] {
    CMD_WR_A = 2'd0,
    CMD_WR_B = 2'd1,
    CMD_MUL  = 2'd2
  } cmd_kind_e;

endpackage

/* hw/rtl/matmul_front.sv */
module matmul_front #(
  parameter int unsigned MAX_DIM    = 8,
  parameter int unsigned ELEM_WIDTH = 16,
  parameter int unsigned AW         = 6
) (
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [matmul_pkg::REQ_W-1:0]           req_type_i,
  input  logic [matmul_pkg::POS_W-1:0]           row_index_i,
  input  logic [matmul_pkg::POS_W-1:0]           col_index_i,
  input  logic signed [matmul_pkg::ELEM_IN_W-1:0] elem_value_i,
  input  logic                                   q_full_i,
  output logic                                   q_push_o,
  output logic [AW+ELEM_WIDTH+1:0]               q_cmd_o
);
  import matmul_pkg::*;

  typedef struct packed {
    cmd_kind_e              kind;
    logic [AW-1:0]          addr;
    logic [ELEM_WIDTH-1:0]  elem;
  } cmd_t;

  cmd_t                       cmd;
  logic                       keep;
  logic                       in_store;
  logic [2*ELEM_IN_W-1:0]     raw;

  assign raw      = {{ELEM_IN_W{1'b0}}, elem_value_i};
  assign in_store = (32'(row_index_i) < MAX_DIM) && (32'(col_index_i) < MAX_DIM);

  always_comb begin
    cmd.addr = AW'(32'(row_index_i) * MAX_DIM + 32'(col_index_i));
    cmd.elem = raw[ELEM_WIDTH-1:0];
    cmd.kind = CMD_MUL;
    keep     = 1'b0;
    unique case (req_type_i)
      REQ_WR_A: begin
        cmd.kind = CMD_WR_A;
        keep     = in_store;
      end
      REQ_WR_B: begin
        cmd.kind = CMD_WR_B;
        keep     = in_store;
      end
      REQ_MUL: begin
        cmd.kind = CMD_MUL;
        keep     = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready_o = ~q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i & keep;
  assign q_cmd_o    = cmd;

endmodule

/* hw/rtl/matmul_fifo.sv */
module matmul_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* hw/rtl/matmul_back.sv */
module matmul_back #(
  parameter int unsigned MAX_DIM    = 8,
  parameter int unsigned ELEM_WIDTH = 16,
  parameter int unsigned AW         = 6,
  parameter int unsigned IDXW       = 3,
  parameter int unsigned DW         = 4
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic [DW-1:0]                             nr_i,
  input  logic [DW-1:0]                             nk_i,
  input  logic [DW-1:0]                             nc_i,
  input  logic                                      q_empty_i,
  input  logic [AW+ELEM_WIDTH+1:0]                  q_cmd_i,
  output logic                                      q_pop_o,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic [matmul_pkg::POS_W-1:0]              out_row_o,
  output logic [matmul_pkg::POS_W-1:0]              out_col_o,
  output logic signed [matmul_pkg::OUT_VALUE_W-1:0] out_value_o,
  output logic                                      out_last_o
);
  import matmul_pkg::*;

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned PRODW = 2 * ELEM_WIDTH;

  typedef struct packed {
    cmd_kind_e              kind;
    logic [AW-1:0]          addr;
    logic [ELEM_WIDTH-1:0]  elem;
  } cmd_t;

  typedef struct packed {
    logic            first;
    logic            lastk;
    logic            last;
    logic [IDXW-1:0] row;
    logic [IDXW-1:0] col;
  } tag_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  cmd_t   cmd;
  state_e state_q, state_d;

  logic signed [ELEM_WIDTH-1:0] mem_a [DEPTH];
  logic signed [ELEM_WIDTH-1:0] mem_b [DEPTH];
  logic signed [ELEM_WIDTH-1:0] rd_a_q, rd_b_q;
  logic signed [PRODW-1:0]      prod_q;
  logic signed [WIDE_W-1:0]     prod_ext;
  logic [OUT_VALUE_W-1:0]       prod_lo, sum, acc_q;

  logic [IDXW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic            k_last, j_last, i_last;
  logic            advance, issue, pop;
  logic            wr_a, wr_b;
  logic [AW-1:0]   addr_a, addr_b;
  tag_t            tag0, tag1_q, tag2_q;
  logic            v1_q, v2_q;

  logic                   out_valid_q;
  logic [POS_W-1:0]       out_row_q, out_col_q;
  logic [OUT_VALUE_W-1:0] out_value_q;
  logic                   out_last_q;

  assign cmd     = q_cmd_i;
  assign advance = ~out_valid_q | out_ready_i;
  assign issue   = (state_q == ST_RUN) & advance;
  assign q_pop_o = pop;
  assign pop     = (state_q == ST_IDLE) & ~q_empty_i;
  assign wr_a    = pop & (cmd.kind == CMD_WR_A);
  assign wr_b    = pop & (cmd.kind == CMD_WR_B);

  assign k_last = (DW'(k_q) == nk_i - 1'b1);
  assign j_last = (DW'(j_q) == nc_i - 1'b1);
  assign i_last = (DW'(i_q) == nr_i - 1'b1);

  assign addr_a = AW'(32'(i_q) * MAX_DIM + 32'(k_q));
  assign addr_b = AW'(32'(k_q) * MAX_DIM + 32'(j_q));

  always_comb begin
    tag0.first = (k_q == '0);
    tag0.lastk = k_last;
    tag0.last  = i_last & j_last;
    tag0.row   = i_q;
    tag0.col   = j_q;
  end

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop && cmd.kind == CMD_MUL) begin
          state_d = ST_RUN;
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
        end
      end
      ST_RUN: begin
        if (issue) begin
          if (k_last) begin
            k_d = '0;
            if (j_last) begin
              j_d = '0;
              if (i_last) begin
                i_d     = '0;
                state_d = ST_IDLE;
              end else begin
                i_d = i_q + 1'b1;
              end
            end else begin
              j_d = j_q + 1'b1;
            end
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign prod_ext = WIDE_W'(prod_q);
  assign prod_lo  = prod_ext[OUT_VALUE_W-1:0];
  assign sum      = tag2_q.first ? prod_lo : acc_q + prod_lo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      if (advance) begin
        v1_q <= issue;
        v2_q <= v1_q;
      end
      if (advance && v2_q && tag2_q.lastk) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // stores: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[cmd.addr] <= cmd.elem;
    end
    if (wr_b) begin
      mem_b[cmd.addr] <= cmd.elem;
    end
    if (advance) begin
      rd_a_q <= mem_a[addr_a];
      rd_b_q <= mem_b[addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      tag1_q <= tag0;
      tag2_q <= tag1_q;
      prod_q <= rd_a_q * rd_b_q;
      if (v2_q) begin
        acc_q <= sum;
        if (tag2_q.lastk) begin
          out_row_q   <= POS_W'(tag2_q.row);
          out_col_q   <= POS_W'(tag2_q.col);
          out_value_q <= sum;
          out_last_q  <= tag2_q.last;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

endmodule

/* hw/rtl/matrix_multiply.sv */
// Dense product C = A*B of signed elements. Write items load one element of A or B per
// cycle while in_ready_o is high; a compute item then emits one word per entry of C in
// row-major order, out_last_o set on the final one. Items pass a small command queue, so
// writes and computes stay in order. A compute uses the one multiply-accumulate unit and
// one read port per store, and stalls while a result waits. Stores are not cleared at
// reset; read only entries that were written. Sizes of 0 act as 1 and sizes above
// MAX_DIM as MAX_DIM; change them only while the block is idle.
module matrix_multiply #(
  parameter int unsigned MAX_DIM    = 8,
  parameter int unsigned ELEM_WIDTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [matmul_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [matmul_pkg::DIM_REG_W-1:0]          cfg_wdata_i,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic [matmul_pkg::REQ_W-1:0]              req_type_i,
  input  logic [matmul_pkg::POS_W-1:0]              row_index_i,
  input  logic [matmul_pkg::POS_W-1:0]              col_index_i,
  input  logic signed [matmul_pkg::ELEM_IN_W-1:0]   elem_value_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic [matmul_pkg::POS_W-1:0]              out_row_o,
  output logic [matmul_pkg::POS_W-1:0]              out_col_o,
  output logic signed [matmul_pkg::OUT_VALUE_W-1:0] out_value_o,
  output logic                                      out_last_o
);
  import matmul_pkg::*;

  localparam int unsigned AW   = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam int unsigned IDXW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned DW   = $clog2(MAX_DIM + 1);
  localparam int unsigned CMDW = AW + ELEM_WIDTH + 2;

  logic [DIM_REG_W-1:0] rows_a_q, inner_dim_q, cols_b_q;
  logic [DW-1:0]        nr, nk, nc;
  logic                 q_push, q_full, q_pop, q_empty;
  logic [CMDW-1:0]      q_wdata, q_rdata;

  function automatic logic [DW-1:0] dim_eff(input logic [DIM_REG_W-1:0] d);
    logic [DW-1:0] r;
    if (d == '0) begin
      r = DW'(1);
    end else if (32'(d) > MAX_DIM) begin
      r = DW'(MAX_DIM);
    end else begin
      r = DW'(d);
    end
    return r;
  endfunction

  assign nr = dim_eff(rows_a_q);
  assign nk = dim_eff(inner_dim_q);
  assign nc = dim_eff(cols_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= DIM_RESET;
      inner_dim_q <= DIM_RESET;
      cols_b_q    <= DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROWS_A:    rows_a_q    <= cfg_wdata_i;
        CFG_INNER_DIM: inner_dim_q <= cfg_wdata_i;
        CFG_COLS_B:    cols_b_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  matmul_front #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH),
    .AW         (AW)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .row_index_i  (row_index_i),
    .col_index_i  (col_index_i),
    .elem_value_i (elem_value_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (q_wdata)
  );

  matmul_fifo #(
    .WIDTH (CMDW),
    .DEPTH (2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  matmul_back #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH),
    .AW         (AW),
    .IDXW       (IDXW),
    .DW         (DW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .nr_i        (nr),
    .nk_i        (nk),
    .nc_i        (nc),
    .q_empty_i   (q_empty),
    .q_cmd_i     (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .out_value_o (out_value_o),
    .out_last_o  (out_last_o)
  );

endmodule

/* hw/rtl/matmul_checker.sv */
module matmul_checker (
  input logic                                      clk_i,
  input logic                                      rst_ni,
  input logic                                      in_valid_i,
  input logic                                      in_ready_o,
  input logic [matmul_pkg::REQ_W-1:0]              req_type_i,
  input logic                                      out_valid_o,
  input logic                                      out_ready_i,
  input logic [matmul_pkg::POS_W-1:0]              out_row_o,
  input logic [matmul_pkg::POS_W-1:0]              out_col_o,
  input logic signed [matmul_pkg::OUT_VALUE_W-1:0] out_value_o,
  input logic                                      out_last_o
);
  import matmul_pkg::*;

  logic [3:0] pend_q;
  logic       mul_in, last_out;

  assign mul_in   = in_valid_i & in_ready_o & (req_type_i == REQ_MUL);
  assign last_out = out_valid_o & out_ready_i & out_last_o;

  // computes accepted but not yet finished
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (mul_in && !last_out) begin
      pend_q <= pend_q + 1'b1;
    end else if (!mul_in && last_out) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_row_o) &&
    $stable(out_col_o) && $stable(out_value_o) && $stable(out_last_o))
    else $error("result word changed while stalled");

  a_out_needs_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != '0)
    else $error("result word without a pending compute");

  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind matrix_multiply matmul_checker u_matmul_checker (.*);
